@@ hw/rtl/aub_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aub_pkg
// shared widths, fixed-point constants and codes of the adaptive upload budget
// ----------------------------------------------------------------------------
package aub_pkg;

    // field and state widths
    localparam int T_W    = 24;             // frame time, us
    localparam int BYT_W  = 32;             // bytes of one frame
    localparam int BUD_W  = 32;             // budget, bytes
    localparam int ST_W   = 40;             // summed upload time
    localparam int SB_W   = 48;             // summed upload bytes
    localparam int FC_W   = 16;             // frame count
    localparam int S2_W   = T_W + 1;        // sum of two probes, half-us
    localparam int CAP_W  = BUD_W + 1;      // double budget
    localparam int EXT_W  = ST_W + 1;       // extra time, half-us
    localparam int PROD_W = S2_W + SB_W;    // slack times bytes
    localparam int CNT_W  = $clog2(PROD_W);
    localparam int EV_W   = 3;

    localparam int MUL_STEPS = S2_W;
    localparam int DIV_STEPS = PROD_W;

    // time constants, us and half-us
    localparam logic [T_W-1:0]  FRAME_US  = T_W'(16667);
    localparam logic [T_W-1:0]  FLOOR_US  = T_W'(4000);
    localparam logic [S2_W-1:0] FRAME2_US = S2_W'(33334);
    localparam logic [S2_W-1:0] FLOOR2_US = S2_W'(8000);

    // register defaults
    localparam logic [BUD_W-1:0] RST_START = BUD_W'(4194304);
    localparam logic [BUD_W-1:0] RST_LEAST = BUD_W'(262144);
    localparam logic [BUD_W-1:0] RST_MOST  = BUD_W'(67108864);

    // configuration register indexes
    localparam logic [1:0] CFG_ADAPT_ENABLE = 2'd0;
    localparam logic [1:0] CFG_START_BUDGET = 2'd1;
    localparam logic [1:0] CFG_LEAST_BUDGET = 2'd2;
    localparam logic [1:0] CFG_MOST_BUDGET  = 2'd3;

    // result event codes
    typedef enum logic [EV_W-1:0] {
        EV_IDLE    = 3'd0,
        EV_ACCUM   = 3'd1,
        EV_HALVED  = 3'd2,
        EV_STALL   = 3'd3,
        EV_NODATA  = 3'd4,
        EV_UPDATED = 3'd5
    } aub_ev_t;

endpackage
`default_nettype wire

@@ hw/rtl/adaptive_upload_budget_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_upload_budget_top
// per-frame texture upload budget, adapted from probe frames
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  s_        | in        | s_valid / s_ready  | frame_time_us, upload_bytes, probe_frame
//  m_        | out       | m_valid / m_ready  | budget_bytes, event_res
//  cfg_      | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
//  one request at a time; an idle, upload or rejected probe passes evaluate
//  and emit, the halving test adds a slack and a compare state, and a full
//  update runs a bit-serial multiply and a bit-serial restoring divide, which
//  negligible extra time skips
//  the result sits in an output register, so the next request is taken while
//  it waits; a stalled m_ side holds only the request that follows
//  aresetn is synchronous, active low, and loads the register defaults
// ----------------------------------------------------------------------------
module adaptive_upload_budget_top
    import aub_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // request channel
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [T_W-1:0]   s_frame_time_us,
    input  wire logic [BYT_W-1:0] s_upload_bytes,
    input  wire logic             s_probe_frame,
    // result channel
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [BUD_W-1:0]      m_budget_bytes,
    output logic [EV_W-1:0]       m_event_res,
    // configuration writes
    input  wire logic             cfg_wr_en,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [BUD_W-1:0] cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE,    // waiting for a request
        ST_EVAL,    // decide frame kind, accumulate
        ST_HSLK,    // slack of last probe for the halving test
        ST_HCMP,    // halving test
        ST_PREP,    // probe slack, s2 * count
        ST_CMP,     // extra time = 2 * sum_time - s2 * count
        ST_CHK,     // extra time above the tiny threshold?
        ST_MUL,     // slack * bytes, one bit per cycle
        ST_DIV,     // product / extra, one bit per cycle
        ST_FIT,     // saturate at double, floor at half
        ST_FIN,     // clamp into least..most
        ST_EMIT     // hand result to output register
    } state_t;

    // clamp into least..most, least first so most wins
    function automatic logic [BUD_W-1:0] clamp_fn(
        input logic [BUD_W-1:0] x,
        input logic [BUD_W-1:0] lo,
        input logic [BUD_W-1:0] hi
    );
        logic [BUD_W-1:0] t;
        t = (x < lo) ? lo : x;
        return (t > hi) ? hi : t;
    endfunction

    state_t                 state_reg;

    // configuration
    logic                   adapt_reg;
    logic [BUD_W-1:0]       start_reg;
    logic [BUD_W-1:0]       least_reg;
    logic [BUD_W-1:0]       most_reg;
    logic                   adapt_next;
    logic [BUD_W-1:0]       start_next;
    logic [BUD_W-1:0]       least_next;
    logic [BUD_W-1:0]       most_next;
    logic                   restart_req;

    // architectural state
    logic [BUD_W-1:0]       budget_reg;
    logic [T_W-1:0]         probe_time_reg;
    logic [ST_W-1:0]        sum_time_reg;
    logic [SB_W-1:0]        sum_bytes_reg;
    logic [FC_W-1:0]        frame_count_reg;

    // captured request
    logic [T_W-1:0]         t_reg;
    logic [BYT_W-1:0]       bytes_reg;
    logic                   probe_reg;

    // working registers
    aub_ev_t                ev_reg;
    logic [T_W-1:0]         slack_reg;
    logic [S2_W-1:0]        s2_reg;
    logic [S2_W-1:0]        slack2_reg;
    logic [EXT_W-1:0]       s2fc_reg;
    logic [FC_W+4:0]        fc20_reg;
    logic [EXT_W-1:0]       extra2_reg;
    logic                   borrow_reg;
    logic [CAP_W-1:0]       cap_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [EXT_W-1:0]       rem_reg;
    logic [CAP_W-1:0]       q_reg;
    logic                   ovf_reg;
    logic [CAP_W-1:0]       fits_reg;
    logic [CNT_W-1:0]       cnt_reg;

    // output register
    logic                   m_valid_reg;
    logic [BUD_W-1:0]       m_budget_reg;
    logic [EV_W-1:0]        m_event_reg;

    // combinational helpers
    logic [ST_W:0]          st_add;
    logic [SB_W:0]          sb_add;
    logic [BUD_W-1:0]       half_floor;
    logic [T_W+2:0]         halve_lim;
    logic [S2_W-1:0]        s2_new;
    logic                   stall_hit;
    logic [S2_W-1:0]        fr_slack2;
    logic [S2_W-1:0]        slack2_mx;
    logic [T_W-1:0]         fr_slack;
    logic [T_W-1:0]         slack_mx;
    logic [EXT_W:0]         cmp_diff;
    logic [SB_W:0]          mul_sum;
    logic [EXT_W:0]         div_rem2;
    logic [EXT_W+1:0]       div_diff;
    logic                   div_ge;
    logic [CAP_W-1:0]       fit_sat;
    logic [CAP_W-1:0]       fit_low;
    logic [BUD_W-1:0]       clamp_start;
    logic [BUD_W-1:0]       fin_budget;
    logic [CAP_W-1:0]       fin_lo;

    // configuration decode; a restart uses the values just written
    always_comb begin
        adapt_next  = adapt_reg;
        start_next  = start_reg;
        least_next  = least_reg;
        most_next   = most_reg;
        restart_req = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ADAPT_ENABLE: begin
                    adapt_next = cfg_wdata[0];
                    // only a rising enable restarts
                    restart_req = cfg_wdata[0] & ~adapt_reg;
                end
                CFG_START_BUDGET: begin
                    start_next  = cfg_wdata;
                    restart_req = (cfg_wdata != start_reg);
                end
                CFG_LEAST_BUDGET: begin
                    least_next  = cfg_wdata;
                    restart_req = (cfg_wdata != least_reg);
                end
                CFG_MOST_BUDGET: begin
                    most_next   = cfg_wdata;
                    restart_req = (cfg_wdata != most_reg);
                end
                default: begin
                    restart_req = 1'b0;
                end
            endcase
        end
        clamp_start = clamp_fn(start_next, least_next, most_next);
    end

    // datapath helpers
    always_comb begin
        // saturating accumulators
        st_add = {1'b0, sum_time_reg} + {(ST_W - T_W + 1)'(0), t_reg};
        sb_add = {1'b0, sum_bytes_reg} + {(SB_W - BYT_W + 1)'(0), bytes_reg};

        // halving: max(least, budget / 2)
        half_floor = (budget_reg >> 1) < least_reg ? least_reg : (budget_reg >> 1);

        // slack of the last probe, whole us
        fr_slack = (probe_time_reg < FRAME_US) ? (FRAME_US - probe_time_reg) : '0;
        slack_mx = (probe_time_reg > fr_slack) ? probe_time_reg : fr_slack;
        slack_mx = (slack_mx > FLOOR_US) ? slack_mx : FLOOR_US;
        halve_lim = {3'b000, probe_time_reg} + {1'b0, slack_reg, 2'b00};

        // probe: stall test and sum of two probes in half-us
        stall_hit = (probe_time_reg != '0)
                  && ({2'b00, t_reg} > {probe_time_reg, 2'b00});
        s2_new = (probe_time_reg != '0)
               ? ({1'b0, probe_time_reg} + {1'b0, t_reg})
               : {t_reg, 1'b0};

        // probe slack in half-us
        fr_slack2 = (s2_reg < FRAME2_US) ? (FRAME2_US - s2_reg) : '0;
        slack2_mx = (s2_reg > fr_slack2) ? s2_reg : fr_slack2;
        slack2_mx = (slack2_mx > FLOOR2_US) ? slack2_mx : FLOOR2_US;

        // 2 * sum_time - s2 * count, borrow in the top bit
        cmp_diff = {1'b0, sum_time_reg, 1'b0} - {1'b0, s2fc_reg};

        // shift-add multiply step
        mul_sum = {1'b0, prod_reg[PROD_W-1:S2_W]}
                + (prod_reg[0] ? {1'b0, sum_bytes_reg} : '0);

        // restoring divide step
        div_rem2 = {rem_reg, prod_reg[PROD_W-1]};
        div_diff = {1'b0, div_rem2} - {2'b00, extra2_reg};
        div_ge   = ~div_diff[EXT_W+1];

        // quotient limited to half..double of the old budget
        fit_sat = (ovf_reg || (q_reg > cap_reg)) ? cap_reg : q_reg;
        fit_low = {2'b00, budget_reg[BUD_W-1:1]};

        // final clamp into least..most
        fin_lo     = (fits_reg < {1'b0, least_reg}) ? {1'b0, least_reg} : fits_reg;
        fin_budget = (fin_lo > {1'b0, most_reg}) ? most_reg : fin_lo[BUD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            adapt_reg       <= 1'b0;
            start_reg       <= RST_START;
            least_reg       <= RST_LEAST;
            most_reg        <= RST_MOST;
            budget_reg      <= clamp_fn(RST_START, RST_LEAST, RST_MOST);
            probe_time_reg  <= '0;
            sum_time_reg    <= '0;
            sum_bytes_reg   <= '0;
            frame_count_reg <= '0;
            m_valid_reg     <= 1'b0;
            ev_reg          <= EV_IDLE;
        end else begin
            adapt_reg <= adapt_next;
            start_reg <= start_next;
            least_reg <= least_next;
            most_reg  <= most_next;

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        t_reg     <= s_frame_time_us;
                        bytes_reg <= s_upload_bytes;
                        probe_reg <= s_probe_frame;
                        state_reg <= ST_EVAL;
                    end
                end

                ST_EVAL: begin
                    ev_reg    <= EV_IDLE;
                    state_reg <= ST_EMIT;
                    if (adapt_reg && !probe_reg && (bytes_reg != '0)) begin
                        sum_time_reg    <= st_add[ST_W] ? '1 : st_add[ST_W-1:0];
                        sum_bytes_reg   <= sb_add[SB_W] ? '1 : sb_add[SB_W-1:0];
                        frame_count_reg <= (&frame_count_reg) ? frame_count_reg
                                         : frame_count_reg + FC_W'(1);
                        ev_reg <= EV_ACCUM;
                        if (probe_time_reg != '0) begin
                            state_reg <= ST_HSLK;
                        end
                    end else if (adapt_reg && probe_reg) begin
                        if (stall_hit) begin
                            sum_time_reg    <= '0;
                            sum_bytes_reg   <= '0;
                            frame_count_reg <= '0;
                            ev_reg          <= EV_STALL;
                        end else begin
                            probe_time_reg <= t_reg;
                            s2_reg         <= s2_new;
                            if ((probe_time_reg == '0) || (frame_count_reg == '0)
                                    || (sum_bytes_reg == '0)) begin
                                sum_time_reg    <= '0;
                                sum_bytes_reg   <= '0;
                                frame_count_reg <= '0;
                                ev_reg          <= EV_NODATA;
                            end else begin
                                state_reg <= ST_PREP;
                            end
                        end
                    end
                end

                ST_HSLK: begin
                    slack_reg <= slack_mx;
                    state_reg <= ST_HCMP;
                end

                ST_HCMP: begin
                    // frame far over the probe allowance
                    if ({3'b000, t_reg} > halve_lim) begin
                        budget_reg <= half_floor;
                        ev_reg     <= EV_HALVED;
                    end
                    state_reg <= ST_EMIT;
                end

                ST_PREP: begin
                    slack2_reg <= slack2_mx;
                    s2fc_reg   <= EXT_W'(s2_reg) * EXT_W'(frame_count_reg);
                    fc20_reg   <= {1'b0, frame_count_reg, 4'b0000}
                                + {3'b000, frame_count_reg, 2'b00};
                    cap_reg    <= {budget_reg, 1'b0};
                    state_reg  <= ST_CMP;
                end

                ST_CMP: begin
                    extra2_reg <= cmp_diff[EXT_W-1:0];
                    borrow_reg <= cmp_diff[EXT_W];
                    state_reg  <= ST_CHK;
                end

                ST_CHK: begin
                    if (!borrow_reg
                            && (extra2_reg > {(EXT_W - FC_W - 5)'(0), fc20_reg})) begin
                        prod_reg  <= {(SB_W)'(0), slack2_reg};
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL;
                    end else begin
                        // negligible extra time: take double
                        q_reg     <= cap_reg;
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_FIT;
                    end
                end

                ST_MUL: begin
                    prod_reg <= {mul_sum, prod_reg[S2_W-1:1]};
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                        cnt_reg   <= '0;
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV: begin
                    prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
                    rem_reg  <= div_ge ? div_diff[EXT_W-1:0] : div_rem2[EXT_W-1:0];
                    // a quotient bit past the top means far above double
                    ovf_reg  <= ovf_reg | q_reg[CAP_W-1];
                    q_reg    <= {q_reg[CAP_W-2:0], div_ge};
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                        state_reg <= ST_FIT;
                    end
                end

                ST_FIT: begin
                    fits_reg  <= (fit_sat < fit_low) ? fit_low : fit_sat;
                    state_reg <= ST_FIN;
                end

                ST_FIN: begin
                    budget_reg      <= fin_budget;
                    sum_time_reg    <= '0;
                    sum_bytes_reg   <= '0;
                    frame_count_reg <= '0;
                    ev_reg          <= EV_UPDATED;
                    state_reg       <= ST_EMIT;
                end

                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_budget_reg <= budget_reg;
                        m_event_reg  <= ev_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // restart on a configuration change; the user must keep the block idle then, the block has no check for it
            if (restart_req) begin
                probe_time_reg  <= '0;
                sum_time_reg    <= '0;
                sum_bytes_reg   <= '0;
                frame_count_reg <= '0;
                budget_reg      <= clamp_start;
            end
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_budget_bytes = m_budget_reg;
    assign m_event_res    = m_event_reg;

endmodule
`default_nettype wire

@@ hw/rtl/aub_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aub_checker
// port-level checks of the adaptive upload budget, bound to the top level
// ----------------------------------------------------------------------------
module aub_checker
    import aub_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic [BUD_W-1:0] m_budget_bytes,
    input wire logic [EV_W-1:0]  m_event_res
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_budget_bytes)
                                && $stable(m_event_res))
        else $error("result changed while stalled");

    // one request at a time
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    // a result shows up only from a request in work
    a_out_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without request");

    // event codes stay within the defined set
    a_event_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_event_res <= EV_UPDATED))
        else $error("undefined event code");

endmodule

bind adaptive_upload_budget_top aub_checker u_aub_checker (.*);
`default_nettype wire

@@ dv/tb_adaptive_upload_budget_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_upload_budget_top
// self-checking bench for the adaptive upload budget
// ----------------------------------------------------------------------------
//  frame requests are driven on the s_ side and scored against an in-bench
//  budget predictor, one result per request in order; directed cases, a
//  register sweep over the clamp extremes, a byte sum grown past 32 bits, then
//  random probe/upload episodes under several budget windows, with random
//  idle gaps on both sides
// ----------------------------------------------------------------------------
module tb_adaptive_upload_budget_top
    import aub_pkg::*;
;

    localparam int          LIMIT_CYCLES   = 4_000_000;
    localparam int          RANDOM_TARGET  = 250;     // adaptive requests per window
    localparam int          WIDE_FRAMES    = 200;
    localparam logic [63:0] SIXTIETH_US    = 64'd16667;
    localparam logic [63:0] MIN_SLACK_US   = 64'd4000;
    localparam logic [63:0] NEGLIGIBLE_US  = 64'd10;
    localparam logic [63:0] SUM_US_MAX     = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] SUM_BYTES_MAX  = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] FRAMES_MAX     = 64'hFFFF;

    // one expected result
    typedef struct packed {
        logic [BUD_W-1:0] budget;
        aub_ev_t          ev;
    } budget_result_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [T_W-1:0]   s_frame_time_us;
    logic [BYT_W-1:0] s_upload_bytes;
    logic             s_probe_frame;
    logic             m_valid;
    logic             m_ready;
    logic [BUD_W-1:0] m_budget_bytes;
    logic [EV_W-1:0]  m_event_res;
    logic             cfg_wr_en;
    logic [1:0]       cfg_index;
    logic [BUD_W-1:0] cfg_wdata;

    adaptive_upload_budget_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_frame_time_us (s_frame_time_us),
        .s_upload_bytes  (s_upload_bytes),
        .s_probe_frame   (s_probe_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_budget_bytes  (m_budget_bytes),
        .m_event_res     (m_event_res),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    // predictor copy of the registers
    logic             cfg_adapt;
    logic [BUD_W-1:0] cfg_start;
    logic [BUD_W-1:0] cfg_least;
    logic [BUD_W-1:0] cfg_most;

    // predictor copy of the state
    logic [BUD_W-1:0] model_budget;
    logic [T_W-1:0]   model_probe_us;
    logic [ST_W-1:0]  model_sum_us;
    logic [SB_W-1:0]  model_sum_bytes;
    logic [FC_W-1:0]  model_frames;

    // results still owed by the block, oldest first
    budget_result_t pending_budgets[$];

    int unsigned cycle_count       = 0;
    int unsigned request_count     = 0;
    int unsigned adaptive_requests = 0;
    int unsigned results_checked   = 0;
    int unsigned mismatches        = 0;
    int unsigned ev_count[6]       = '{default: 0};
    bit          calm              = 0;   // no idling on either side while set
    bit          valid_held        = 0;   // s_valid left high for a back-to-back request

    // ------------------------------------------------------------------------
    // clock, watchdog
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, pending_budgets.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // budget predictor
    // ------------------------------------------------------------------------

    // least first, then most: most wins when the window is inverted
    function automatic logic [BUD_W-1:0] window_clamp(input logic [63:0] x);
        logic [63:0] t;
        t = (x < 64'(cfg_least)) ? 64'(cfg_least) : x;
        return (t > 64'(cfg_most)) ? cfg_most : t[BUD_W-1:0];
    endfunction

    function automatic void clear_sums();
        model_sum_us    = '0;
        model_sum_bytes = '0;
        model_frames    = '0;
    endfunction

    function automatic void restart_adaptation();
        model_probe_us = '0;
        clear_sums();
        model_budget = window_clamp(64'(cfg_start));
    endfunction

    function automatic void apply_cfg_write(input logic [1:0] idx, input logic [BUD_W-1:0] val);
        case (idx)
            CFG_ADAPT_ENABLE: begin
                // only a rising enable restarts
                if (val[0] && !cfg_adapt) restart_adaptation();
                cfg_adapt = val[0];
            end
            CFG_START_BUDGET: if (val != cfg_start) begin
                cfg_start = val;
                restart_adaptation();
            end
            CFG_LEAST_BUDGET: if (val != cfg_least) begin
                cfg_least = val;
                restart_adaptation();
            end
            CFG_MOST_BUDGET: if (val != cfg_most) begin
                cfg_most = val;
                restart_adaptation();
            end
            default: ;
        endcase
    endfunction

    // probe frame: stall check, scene cost from two probes, new budget
    function automatic aub_ev_t probe_update(input logic [63:0] t);
        logic [63:0]  prev, s2, slack2, lhs, rhs, cap, fits, low, nxt, extra2;
        logic [127:0] quo;
        prev = 64'(model_probe_us);
        if (prev != 0 && t > 4 * prev) begin
            clear_sums();
            return EV_STALL;
        end
        model_probe_us = t[T_W-1:0];
        s2 = (prev != 0) ? prev + t : 2 * t;
        // slack in half-us: max of scene cost, rest of the frame, floor
        slack2 = s2;
        if (s2 < 2 * SIXTIETH_US && 2 * SIXTIETH_US - s2 > slack2)
            slack2 = 2 * SIXTIETH_US - s2;
        if (2 * MIN_SLACK_US > slack2)
            slack2 = 2 * MIN_SLACK_US;
        if (prev == 0 || model_frames == 0 || model_sum_bytes == 0) begin
            clear_sums();
            return EV_NODATA;
        end
        cap = 64'(model_budget) << 1;
        lhs = 64'(model_sum_us) << 1;
        rhs = (s2 + 2 * NEGLIGIBLE_US) * 64'(model_frames);
        if (lhs > rhs) begin
            extra2 = lhs - s2 * 64'(model_frames);
            quo    = (128'(slack2) * 128'(model_sum_bytes)) / 128'(extra2);
            fits   = (quo > 128'(cap)) ? cap : quo[63:0];
        end else begin
            // negligible extra time
            fits = cap;
        end
        low = 64'(model_budget) >> 1;
        nxt = (fits < low) ? low : ((fits > cap) ? cap : fits);
        model_budget = window_clamp(nxt);
        clear_sums();
        return EV_UPDATED;
    endfunction

    function automatic budget_result_t predict_frame(input logic [T_W-1:0] t,
                                                     input logic [BYT_W-1:0] b,
                                                     input logic p);
        budget_result_t r;
        aub_ev_t        ev;
        logic [63:0]    w, pt, slack, half;
        ev = EV_IDLE;
        if (cfg_adapt) begin
            if (p) begin
                ev = probe_update(64'(t));
            end else if (b != 0) begin
                // saturating accumulation over upload frames
                w = 64'(model_sum_us) + 64'(t);
                model_sum_us = (w > SUM_US_MAX) ? SUM_US_MAX[ST_W-1:0] : w[ST_W-1:0];
                w = 64'(model_sum_bytes) + 64'(b);
                model_sum_bytes = (w > SUM_BYTES_MAX) ? SUM_BYTES_MAX[SB_W-1:0] : w[SB_W-1:0];
                w = 64'(model_frames) + 1;
                model_frames = (w > FRAMES_MAX) ? FRAMES_MAX[FC_W-1:0] : w[FC_W-1:0];
                ev = EV_ACCUM;
                if (model_probe_us != 0) begin
                    pt    = 64'(model_probe_us);
                    slack = pt;
                    if (pt < SIXTIETH_US && SIXTIETH_US - pt > slack) slack = SIXTIETH_US - pt;
                    if (MIN_SLACK_US > slack) slack = MIN_SLACK_US;
                    // frame far over the probe allowance halves at once
                    if (64'(t) > pt + 4 * slack) begin
                        half = 64'(model_budget) >> 1;
                        model_budget = (half < 64'(cfg_least)) ? cfg_least : half[BUD_W-1:0];
                        ev = EV_HALVED;
                    end
                end
            end
        end
        r.budget = model_budget;
        r.ev     = ev;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure
    initial begin
        int hold;
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            hold = calm ? 64 : $urandom_range(1, 8);
            m_ready <= 1'b1;
            repeat (hold) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // one frame request; the expectation is formed at the accepting edge
    task automatic send_frame(input logic [T_W-1:0] t, input logic [BYT_W-1:0] b,
                              input logic p);
        int gap;
        s_valid         <= 1'b1;
        s_frame_time_us <= t;
        s_upload_bytes  <= b;
        s_probe_frame   <= p;
        do @(posedge aclk); while (!s_ready);
        if (cfg_adapt && (p || b != 0)) adaptive_requests++;
        request_count++;
        pending_budgets.insert(pending_budgets.size(), predict_frame(t, b, p));
        gap = pick_gap();
        if (gap > 0) begin
            s_valid    <= 1'b0;
            valid_held  = 1'b0;
            repeat (gap) @(posedge aclk);
        end else begin
            valid_held = 1'b1;
        end
    endtask

    // stop requesting and wait for every owed result
    task automatic drain();
        if (valid_held) begin
            s_valid    <= 1'b0;
            valid_held  = 1'b0;
        end
        while (pending_budgets.size() != 0) @(posedge aclk);
    endtask

    // register writes only while the block is idle
    task automatic write_cfg(input logic [1:0] idx, input logic [BUD_W-1:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        apply_cfg_write(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    budget_result_t owed;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_budgets.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: budget %0d event %0d",
                             m_budget_bytes, m_event_res);
            end else begin
                owed = pending_budgets[0];
                pending_budgets.delete(0);
                results_checked++;
                ev_count[int'(owed.ev)]++;
                if (m_budget_bytes !== owed.budget || m_event_res !== owed.ev) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: budget exp %0d got %0d, event exp %0d got %0d",
                                 results_checked, owed.budget, m_budget_bytes,
                                 owed.ev, m_event_res);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // random content
    // ------------------------------------------------------------------------
    function automatic logic [T_W-1:0] sat_time(input logic [63:0] v);
        return (v > 64'hFF_FFFF) ? '1 : v[T_W-1:0];
    endfunction

    function automatic logic [T_W-1:0] rand_probe_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return '0;
        if (r < 15) return T_W'($urandom);
        if (r < 25) return T_W'($urandom_range(1, 2000));
        return T_W'($urandom_range(2000, 30000));
    endfunction

    function automatic logic [BYT_W-1:0] rand_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return '1;
        if (r < 35) return $urandom;
        return ($urandom >> $urandom_range(0, 31)) | 32'd1;
    endfunction

    // optional opening probe, a run of frames, a closing probe
    task automatic run_episode();
        logic [T_W-1:0] base;
        logic [63:0]    t;
        int             n;
        int             r;
        if ($urandom_range(0, 1) == 0 || model_probe_us == 0) begin
            base = rand_probe_time();
            send_frame(base, $urandom, 1'b1);
        end
        base = model_probe_us;
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // idle noise: nothing uploaded
                send_frame(T_W'($urandom), '0, 1'b0);
            end else if (r < 14) begin
                // far over the allowance
                t = ($urandom_range(0, 1) == 0) ? 64'hFF_FFFF
                                                : 64'(base) * 5 + 64'd20000 + $urandom_range(0, 5000);
                send_frame(sat_time(t), rand_bytes(), 1'b0);
            end else if (r < 22) begin
                // next to no extra time
                send_frame(sat_time(64'(base) + $urandom_range(0, 12)), rand_bytes(), 1'b0);
            end else begin
                send_frame(sat_time(64'(base) + $urandom_range(0, 6000)), rand_bytes(), 1'b0);
            end
        end
        r = $urandom_range(0, 99);
        if (r < 10)
            t = 64'(base) * 4 + 1 + $urandom_range(0, 1000);      // stall
        else if (r < 15)
            t = 64'(rand_probe_time());
        else
            t = 64'(base) + $urandom_range(0, 400) - 200;
        if (t[63]) t = 0;
        send_frame(sat_time(t), $urandom, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // adaptation is off after reset: nothing moves
    task automatic test_disabled_after_reset();
        send_frame(T_W'(16000), 32'd1000, 1'b1);
        send_frame(T_W'(20000), 32'd5000000, 1'b0);
        send_frame('1, '1, 1'b0);
    endtask

    task automatic test_directed_cases();
        write_cfg(CFG_ADAPT_ENABLE, 32'd1);
        send_frame(T_W'(123), '0, 1'b0);                  // nothing uploaded
        send_frame('0, '1, 1'b1);                         // zero probe, bytes ignored
        send_frame(T_W'(16000), 32'd4194304, 1'b0);       // no previous probe, no halving
        send_frame(T_W'(16000), '0, 1'b1);                // first real probe: no data
        repeat (3) send_frame(T_W'(17000), 32'd2097152, 1'b0);
        send_frame(T_W'(16000), '0, 1'b1);                // update, capped at double
        repeat (2) send_frame(T_W'(16000), 32'd1048576, 1'b0);
        send_frame(T_W'(16000), '0, 1'b1);                // negligible extra time
        send_frame('1, '1, 1'b0);                         // halved
        send_frame(T_W'(16020), 32'd1, 1'b0);
        send_frame(T_W'(16000), '0, 1'b1);                // tiny fit, floored at half
        send_frame(T_W'(64001), '0, 1'b1);                // stall rejected
        send_frame(T_W'(64000), '0, 1'b1);                // four times exactly is fine
        send_frame('0, 32'd5, 1'b0);                      // zero-time upload frame
        send_frame(T_W'(320001), 32'd77, 1'b0);           // just over the allowance
        send_frame('1, '1, 1'b1);                         // stall with bytes on a probe
        send_frame(T_W'(256000), '0, 1'b1);
        write_cfg(CFG_ADAPT_ENABLE, 32'd0);
        send_frame(T_W'(16000), '0, 1'b1);                // off: idle
        send_frame(T_W'(30000), 32'd1000, 1'b0);
    endtask

    // budget window extremes, writes that do and do not restart
    task automatic test_register_writes();
        write_cfg(CFG_ADAPT_ENABLE, 32'd1);
        write_cfg(CFG_ADAPT_ENABLE, 32'd1);               // already on: no restart
        send_frame(T_W'(20000), '0, 1'b1);
        send_frame(T_W'(21000), 32'd3000000, 1'b0);
        write_cfg(CFG_START_BUDGET, cfg_start);           // same value: sums kept
        send_frame(T_W'(20000), '0, 1'b1);
        // inverted window: most wins
        write_cfg(CFG_LEAST_BUDGET, '1);
        write_cfg(CFG_MOST_BUDGET, '0);
        send_frame(T_W'(1000), '0, 1'b1);
        send_frame(T_W'(3000), 32'd123456, 1'b0);
        send_frame(T_W'(1000), '0, 1'b1);
        // widest window, largest start
        write_cfg(CFG_LEAST_BUDGET, '0);
        write_cfg(CFG_MOST_BUDGET, '1);
        write_cfg(CFG_START_BUDGET, '1);
        send_frame(T_W'(1000), '0, 1'b1);
        send_frame(T_W'(1000), 32'd1, 1'b0);
        send_frame(T_W'(1000), '0, 1'b1);                 // double of the top saturates
        send_frame('1, 32'd9, 1'b0);
        write_cfg(CFG_START_BUDGET, '0);
        send_frame(T_W'(1000), '0, 1'b1);
        send_frame('1, 32'd9, 1'b0);                      // halving a zero budget
        // only bit 0 of the enable counts
        write_cfg(CFG_ADAPT_ENABLE, 32'hFFFF_FFFE);
        send_frame(T_W'(5000), 32'd100, 1'b0);
        write_cfg(CFG_ADAPT_ENABLE, 32'd1);
        write_cfg(CFG_START_BUDGET, 32'd4194304);
        write_cfg(CFG_LEAST_BUDGET, 32'd262144);
        write_cfg(CFG_MOST_BUDGET, 32'd67108864);
    endtask

    // full-scale frames back to back: byte sums well past 32 bits
    task automatic test_wide_accumulators();
        calm = 1;
        write_cfg(CFG_ADAPT_ENABLE, 32'd0);
        write_cfg(CFG_ADAPT_ENABLE, 32'd1);
        send_frame(T_W'(16000), '0, 1'b1);
        repeat (WIDE_FRAMES) send_frame('1, '1, 1'b0);
        send_frame(T_W'(16000), '0, 1'b1);
        calm = 0;
    endtask

    // random episodes under one budget window
    task automatic random_window(input logic [BUD_W-1:0] start_b, input logic [BUD_W-1:0] least_b,
                                 input logic [BUD_W-1:0] most_b);
        int unsigned first;
        write_cfg(CFG_START_BUDGET, start_b);
        write_cfg(CFG_LEAST_BUDGET, least_b);
        write_cfg(CFG_MOST_BUDGET, most_b);
        write_cfg(CFG_ADAPT_ENABLE, 32'd1);
        first = adaptive_requests;
        while (adaptive_requests - first < RANDOM_TARGET) begin
            calm = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 24) == 0) begin
                // a short stretch with adaptation off, then a restart
                write_cfg(CFG_ADAPT_ENABLE, 32'd0);
                repeat ($urandom_range(1, 3))
                    send_frame(T_W'($urandom), rand_bytes(), 1'($urandom));
                write_cfg(CFG_ADAPT_ENABLE, 32'd1);
            end
            run_episode();
        end
        calm = 0;
    endtask

    task automatic test_random_traffic();
        random_window(32'd4194304, 32'd262144, 32'd67108864);
        random_window(32'd2097152, 32'd1048576, 32'd8388608);
        random_window(32'd4194304, 32'd50000000, 32'd3000000);   // inverted
        random_window('1, '0, '1);
        random_window(32'd1, '0, '1);
        random_window($urandom, $urandom >> $urandom_range(0, 31), $urandom);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_frame_time_us <= '0;
        s_upload_bytes  <= '0;
        s_probe_frame   <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= CFG_ADAPT_ENABLE;
        cfg_wdata       <= '0;
        cfg_adapt = 1'b0;
        cfg_start = RST_START;
        cfg_least = RST_LEAST;
        cfg_most  = RST_MOST;
        restart_adaptation();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_disabled_after_reset();
        test_directed_cases();
        test_register_writes();
        test_wide_accumulators();
        test_random_traffic();

        // settle, then give a late or extra result time to show up
        drain();
        repeat (300) @(posedge aclk);

        $display("%0d frame requests (%0d while adapting), %0d results checked, %0d mismatches",
                 request_count, adaptive_requests, results_checked, mismatches);
        $display("events: idle %0d, accumulated %0d, halved %0d, stall %0d, no data %0d, updated %0d",
                 ev_count[0], ev_count[1], ev_count[2], ev_count[3], ev_count[4], ev_count[5]);
        if (mismatches == 0 && pending_budgets.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
